/* hdl/itm0_pkg.sv */
// Shared types and codes for the interval timer (mode 0 counting only).
// Used by every module of the block; depends on nothing.
package itm0_pkg;

  typedef enum logic [1:0] {
    ACT_CONTROL = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_READ    = 2'd2,
    ACT_TICK    = 2'd3
  } action_e;

  localparam logic [2:0] ACC_LATCH   = 3'd0;
  localparam logic [2:0] ACC_LSB     = 3'd1;
  localparam logic [2:0] ACC_MSB     = 3'd2;
  localparam logic [2:0] ACC_WORD_LO = 3'd3;
  localparam logic [2:0] ACC_WORD_HI = 3'd4;

  localparam logic [1:0] ACC_FIELD_LATCH = 2'd0;
  localparam logic [2:0] MODE_TERM       = 3'd0;

  localparam logic [15:0] COUNT_WRAP = 16'hFFFF;
  localparam logic [15:0] COUNT_ONE  = 16'h0001;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  typedef struct packed {
    action_e    action;
    logic [1:0] counter_index;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } result_t;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       out_rise;
  } lane_stat_t;

endpackage

/* hdl/itm0_in_stage.sv */
// Input register of the interval timer: holds one accepted item.
// Depends on itm0_pkg.
module itm0_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  itm0_pkg::item_t item_i,
  input  logic           adv_i,
  output logic           valid_o,
  output itm0_pkg::item_t item_o
);
  import itm0_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign ready_o = !valid_q || adv_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

/* hdl/itm0_lane.sv */
// One 16-bit down counter with its latch, access state, mode and out level.
// Depends on itm0_pkg.
module itm0_lane #(
  parameter int unsigned LANE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itm0_pkg::item_t      item_i,
  input  logic                 fire_i,
  output itm0_pkg::lane_stat_t stat_o
);
  import itm0_pkg::*;

  localparam logic [1:0] LaneSel = 2'(LANE);

  logic [15:0] count_q, count_d;
  logic [15:0] latch_q, latch_d;
  logic [2:0]  mode_q, mode_d;
  logic [2:0]  acc_q, acc_d;
  logic        out_q, out_d;
  logic        load;
  logic [15:0] load_val;
  logic        idx_hit;

  assign idx_hit = (item_i.counter_index == LaneSel);

  always_comb begin
    count_d  = count_q;
    latch_d  = latch_q;
    mode_d   = mode_q;
    acc_d    = acc_q;
    out_d    = out_q;
    load     = 1'b0;
    load_val = '0;
    unique case (item_i.action)
      ACT_CONTROL: begin
        if (item_i.data_byte[7:6] == LaneSel) begin
          if (item_i.data_byte[5:4] == ACC_FIELD_LATCH) begin
            latch_d = count_q;
          end else begin
            acc_d  = {1'b0, item_i.data_byte[5:4]};
            mode_d = item_i.data_byte[3:1];
          end
        end
      end
      ACT_WRITE: begin
        if (idx_hit) begin
          unique case (acc_q)
            ACC_LSB: begin
              load     = 1'b1;
              load_val = {8'h00, item_i.data_byte};
            end
            ACC_MSB: begin
              load     = 1'b1;
              load_val = {item_i.data_byte, 8'h00};
            end
            ACC_WORD_LO: begin
              latch_d = {8'h00, item_i.data_byte};
              acc_d   = ACC_WORD_HI;
            end
            ACC_WORD_HI: begin
              load     = 1'b1;
              load_val = {item_i.data_byte, latch_q[7:0]};
              acc_d    = ACC_WORD_LO;
            end
            default: begin
            end
          endcase
        end
      end
      ACT_READ: begin
      end
      ACT_TICK: begin
        if (mode_q == MODE_TERM) begin
          if (count_q == '0) begin
            count_d = COUNT_WRAP;
          end else begin
            count_d = count_q - COUNT_ONE;
            if (count_q == COUNT_ONE) begin
              out_d = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      latch_d = '0;
      if (mode_q == MODE_TERM) begin
        count_d = load_val;
        out_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      latch_q <= '0;
      mode_q  <= '0;
      acc_q   <= ACC_LATCH;
      out_q   <= 1'b0;
    end else if (fire_i) begin
      count_q <= count_d;
      latch_q <= latch_d;
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      out_q   <= out_d;
    end
  end

  assign stat_o.rd_byte  = (item_i.action == ACT_READ && idx_hit) ? latch_q[7:0] : 8'h00;
  assign stat_o.out_rise = !out_q && out_d;
endmodule

/* hdl/itm0_out_stage.sv */
// Result register of the interval timer: holds one result until taken.
// Depends on itm0_pkg.
module itm0_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  itm0_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             valid_o,
  output itm0_pkg::result_t res_o
);
  import itm0_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

/* hdl/interval_timer_mode0.sv */
// Top level of the interval timer: input register, counter lanes, result register.
// Depends on itm0_pkg, itm0_in_stage, itm0_lane and itm0_out_stage.
//
// Channel  | Dir | Handshake                   | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready | tuser: action; tdata: counter_index, data_byte
// m_axis   | out | m_axis_tvalid/m_axis_tready | tdata: read_data, irq
//
// One item per cycle sustained unless the result is stalled; each item yields one
// result through the input register, the lane update and then the result register.
// All counter state and both valid flags clear on rst_ni (asynchronous, active low).
// A stalled result register holds the item in the input register; a new item is still
// taken in the cycle the waiting one moves on.
module interval_timer_mode0 #(
  parameter int unsigned NUM_COUNTERS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] counter_index, [9:2] data_byte, [15:10] zero
  input  logic [itm0_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] read_data, [8] irq, [15:9] zero
  output logic [itm0_pkg::OutDataW-1:0] m_axis_tdata
);
  import itm0_pkg::*;

  item_t      in_item;
  item_t      cur_item;
  logic       cur_valid;
  logic       out_valid;
  logic       adv;
  result_t    res_d;
  result_t    res_q;
  lane_stat_t stat [NUM_COUNTERS];
  logic [7:0] rd_or;

  assign in_item.action        = action_e'(s_axis_tuser);
  assign in_item.counter_index = s_axis_tdata[1:0];
  assign in_item.data_byte     = s_axis_tdata[9:2];

  assign adv = cur_valid && (!out_valid || m_axis_tready);

  itm0_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .adv_i   (adv),
    .valid_o (cur_valid),
    .item_o  (cur_item)
  );

  for (genvar g = 0; g < NUM_COUNTERS; g++) begin : g_lane
    itm0_lane #(
      .LANE (g)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .item_i (cur_item),
      .fire_i (adv),
      .stat_o (stat[g])
    );
  end

  always_comb begin
    rd_or = 8'h00;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      rd_or = rd_or | stat[i].rd_byte;
    end
  end

  assign res_d.read_data = rd_or;
  assign res_d.irq       = stat[0].out_rise;

  itm0_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .res_i   (res_d),
    .ready_i (m_axis_tready),
    .valid_o (out_valid),
    .res_o   (res_q)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, res_q.irq, res_q.read_data};

`ifndef SYNTHESIS
  a_irq_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'h00)
    else $error("irq and read data in one result");

  a_rise_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat[0].out_rise |-> cur_item.action == ACT_TICK)
    else $error("counter 0 out rose without a tick");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid && out_valid && !m_axis_tready |=> cur_valid)
    else $error("item dropped while result stalled");

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid)
    else $error("advanced item left no result");
`endif
endmodule
